// ----- src/tib_pkg.sv -----
// Shared types and constants for the telnet IAC byte filter.
// No dependencies; imported by the front end, queue, back end and top level.
package tib_pkg;

	localparam logic [7:0] BYTE_IAC   = 8'd255;
	localparam logic [7:0] BYTE_DONT  = 8'd254;
	localparam logic [7:0] BYTE_DO    = 8'd253;
	localparam logic [7:0] BYTE_WONT  = 8'd252;
	localparam logic [7:0] BYTE_WILL  = 8'd251;
	localparam logic [7:0] BYTE_SB    = 8'd250;
	localparam logic [7:0] BYTE_SE    = 8'd240;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_NUL   = 8'd0;
	localparam logic [7:0] OPT_BINARY = 8'd0;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TELNET_MODE = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_DATA = 4'b0001,
		ST_IAC  = 4'b0010,
		ST_VERB = 4'b0100,
		ST_SUB  = 4'b1000
	} esc_state_t;

	typedef enum logic [1:0] {
		VERB_WILL = 2'd0,
		VERB_WONT = 2'd1,
		VERB_DO   = 2'd2,
		VERB_DONT = 2'd3
	} verb_t;

	typedef enum logic [1:0] {
		CMD_SINGLE = 2'd0,
		CMD_DOUBLE = 2'd1,
		CMD_REPLY  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       to_network;
		logic [7:0] data;
	} tib_cmd_t;

	typedef struct packed {
		logic raw_mode;
		logic telnet_mode;
	} tib_cfg_t;

endpackage

// ----- src/tib_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface tib_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface tib_out_if;
	logic       valid;
	logic       ready;
	logic       to_network;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output to_network, output out_byte, output last_of_run,
		input ready);
	modport sink (input valid, input to_network, input out_byte, input last_of_run,
		output ready);
endinterface

// ----- src/tib_front.sv -----
// Front end: configuration registers, IAC decoder and classification into commands.
// Depends on tib_pkg and tib_in_if.
module tib_front
	import tib_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tib_in_if.sink                req,
	input  logic                  full,
	output logic                  push,
	output tib_cmd_t              push_cmd
);

	tib_cfg_t   cfg_q;
	esc_state_t state_q, state_d;
	verb_t      verb_q, verb_d;
	logic       binary_q, binary_d;
	logic       accept;
	logic [7:0] c;
	logic [7:0] verb_off;

	assign req.ready = !full;
	assign accept    = req.valid && req.ready;
	assign c         = req.data_byte;
	assign verb_off  = c - BYTE_WILL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_mode    <= 1'b0;
			cfg_q.telnet_mode <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAW_MODE:    cfg_q.raw_mode    <= cfg_data[0];
				REG_TELNET_MODE: cfg_q.telnet_mode <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		verb_d   = verb_q;
		binary_d = binary_q;
		push     = 1'b0;
		push_cmd = '{kind: CMD_SINGLE, to_network: 1'b0, data: c};
		if (req.req_type) begin
			push                = 1'b1;
			push_cmd.to_network = 1'b1;
			if (cfg_q.telnet_mode && c == BYTE_IAC)
				push_cmd.kind = CMD_DOUBLE;
		end else if (!cfg_q.raw_mode && (c == BYTE_LF || c == BYTE_NUL)) begin
			push = 1'b0;
		end else if (c == BYTE_IAC && cfg_q.telnet_mode) begin
			if (state_q == ST_IAC) begin
				state_d = ST_DATA;
				push    = 1'b1;
			end else begin
				state_d = ST_IAC;
			end
		end else begin
			unique case (state_q)
				ST_IAC: begin
					if (c >= BYTE_WILL && c <= BYTE_DONT) begin
						verb_d  = verb_t'(verb_off[1:0]);
						state_d = ST_VERB;
					end else if (c == BYTE_SB) begin
						state_d = ST_SUB;
					end else begin
						state_d = ST_DATA;
					end
				end
				ST_VERB: begin
					state_d       = ST_DATA;
					push_cmd.kind = CMD_REPLY;
					if (c == OPT_BINARY) begin
						unique case (verb_q)
							VERB_DO: begin
								push = !binary_q;
								push_cmd.data = BYTE_WILL;
								binary_d = 1'b1;
							end
							VERB_DONT: begin
								push = binary_q;
								push_cmd.data = BYTE_WONT;
								binary_d = 1'b0;
							end
							VERB_WILL: begin
								push = !binary_q;
								push_cmd.data = BYTE_DO;
								binary_d = 1'b1;
							end
							VERB_WONT: begin
								push = binary_q;
								push_cmd.data = BYTE_DONT;
								binary_d = 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_SUB: begin
					if (c == BYTE_SE)
						state_d = ST_DATA;
				end
				ST_DATA: begin
					push = 1'b1;
				end
				default: begin
					state_d = ST_DATA;
				end
			endcase
		end
		if (!accept) begin
			push     = 1'b0;
			state_d  = state_q;
			verb_d   = verb_q;
			binary_d = binary_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DATA;
			verb_q   <= VERB_WILL;
			binary_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			verb_q   <= verb_d;
			binary_q <= binary_d;
		end
	end

	a_binary_with_reply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(binary_q) |-> $past(push) && $past(push_cmd.kind) == CMD_REPLY)
		else $error("binary mode changed without a reply");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

endmodule

// ----- src/tib_queue.sv -----
// Short command queue that decouples the decoder from the result expander.
// Depends on tib_pkg.
module tib_queue
	import tib_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tib_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output tib_cmd_t head_cmd
);

	tib_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

// ----- src/tib_back.sv -----
// Back end: expands each queued command into one to three result items.
// Depends on tib_pkg and tib_out_if.
module tib_back
	import tib_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  tib_cmd_t head_cmd,
	output logic     pop,
	tib_out_if.source rsp
);

	logic [1:0] beat_q;
	logic       load;
	logic       beat_last;
	logic [7:0] beat_byte;
	logic       out_valid_q;
	logic       to_network_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	always_comb begin
		beat_byte = head_cmd.data;
		beat_last = 1'b1;
		unique case (head_cmd.kind)
			CMD_SINGLE: beat_last = 1'b1;
			CMD_DOUBLE: beat_last = beat_q == 2'd1;
			CMD_REPLY: begin
				beat_last = beat_q == 2'd2;
				if (beat_q == 2'd0)
					beat_byte = BYTE_IAC;
				else if (beat_q == 2'd2)
					beat_byte = OPT_BINARY;
			end
			default: beat_last = 1'b1;
		endcase
	end

	assign load = head_valid && (!out_valid_q || rsp.ready);
	assign pop  = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				beat_q <= beat_last ? 2'd0 : beat_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			to_network_q <= head_cmd.to_network;
			out_byte_q   <= beat_byte;
			last_q       <= beat_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.to_network  = to_network_q;
	assign rsp.out_byte    = out_byte_q;
	assign rsp.last_of_run = last_q;

	a_beat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 2'd3)
		else $error("beat counter out of range");
	a_beat_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 2'd0 |-> head_valid)
		else $error("command left queue mid-expansion");

endmodule

// ----- src/telnet_iac_byte_filter.sv -----
// Path: the first result of an item is written into the command queue when the item is
// accepted, then into the output register once that register is empty or being taken.
// Throughput: one item per cycle while the queue is not full; the output gives one
// result per cycle while rsp.ready is high, so an item with two (doubled IAC) or
// three results (option reply) holds it while the four-entry queue keeps accepting input.
// Reset: asynchronous, clears decoder state, queue and output; raw_mode 0, telnet_mode 1.
module telnet_iac_byte_filter
	import tib_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tib_in_if.sink                req,
	tib_out_if.source             rsp
);

	logic     push, pop, full, head_valid;
	tib_cmd_t push_cmd, head_cmd;

	tib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.full      (full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tib_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tib_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
